>>> design/qts_pkg.sv
// qts_pkg: types, result kind codes and per-byte tokenizer functions
// used by quoted_token_splitter_unit; no dependencies
package qts_pkg;

    localparam int RES_MAX = 5;
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);

    // result kinds
    localparam logic [2:0] KIND_BYTE  = 3'd0;
    localparam logic [2:0] KIND_END   = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_ESC   = 3'd3;
    localparam logic [2:0] KIND_QUOTE = 3'd4;

    // quote state codes, code 3 behaves as single quote
    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    // held byte counts
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] tbyte;
    } res_t;

    // tokenizer state plus the result list being built for one transfer
    typedef struct packed {
        logic [1:0]               quote_kind;
        logic                     escape_pending;
        logic [7:0]               held0;
        logic [7:0]               held1;
        logic [1:0]               held_count;
        logic                     token_open;
        logic [RES_CNT_W-1:0]     count;
        res_t [RES_MAX-1:0]       ent;
    } work_t;

    function automatic work_t push(work_t w, logic [2:0] k, logic [7:0] b);
        work_t r;
        r = w;
        if (r.count < RES_CNT_W'(RES_MAX))
        begin
            r.ent[r.count[$clog2(RES_MAX)-1:0]] = '{kind: k, tbyte: b};
            r.count = r.count + RES_CNT_W'(1);
        end
        return r;
    endfunction

    function automatic work_t emit_byte(work_t w, logic [7:0] b);
        work_t r;
        r = push(w, KIND_BYTE, b);
        r.token_open = 1'b1;
        return r;
    endfunction

    function automatic work_t close_if_open(work_t w);
        work_t r;
        r = w;
        if (r.token_open)
        begin
            r = push(r, KIND_END, 8'h00);
            r.token_open = 1'b0;
        end
        return r;
    endfunction

    function automatic logic is_leader(logic [7:0] b);
        return (b == 8'hC2) || (b == 8'hE1) || (b == 8'hE2) || (b == 8'hE3);
    endfunction

    function automatic logic second_ok(logic [7:0] lead, logic [7:0] b);
        logic ok;
        ok = 1'b0;
        if (lead == 8'hE1)
            ok = (b == 8'h9A);
        else if (lead == 8'hE2)
            ok = (b == 8'h80) || (b == 8'h81);
        else if (lead == 8'hE3)
            ok = (b == 8'h80);
        return ok;
    endfunction

    function automatic logic triple_ok(logic [7:0] a, logic [7:0] m, logic [7:0] c);
        logic ok;
        ok = 1'b0;
        if (a == 8'hE1)
            ok = (m == 8'h9A) && (c == 8'h80);
        else if (a == 8'hE2 && m == 8'h80)
            ok = (c >= 8'h80 && c <= 8'h8B) || (c == 8'hA8) || (c == 8'hA9)
                 || (c == 8'hAF);
        else if (a == 8'hE2 && m == 8'h81)
            ok = (c == 8'h9F);
        else if (a == 8'hE3)
            ok = (m == 8'h80) && (c == 8'h80);
        return ok;
    endfunction

    // one byte through the escape / quote / whitespace rules
    function automatic work_t feed(work_t w, logic [7:0] b);
        work_t      r;
        logic [7:0] m;
        logic [7:0] qc;
        r  = w;
        m  = b;
        qc = (r.quote_kind == QUOTE_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
        if (r.escape_pending)
        begin
            if (b == 8'h6E)
                m = 8'h0A;
            else if (b == 8'h74)
                m = 8'h09;
            else if (b == 8'h72)
                m = 8'h0D;
            r = emit_byte(r, m);
            r.escape_pending = 1'b0;
        end
        else if (b == CH_BSLASH)
        begin
            r.escape_pending = 1'b1;
        end
        else if (r.quote_kind == QUOTE_NONE)
        begin
            if (b == CH_DQUOTE || b == CH_SQUOTE)
            begin
                r = close_if_open(r);
                r.quote_kind = (b == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
            end
            else if (is_leader(b))
            begin
                r.held0      = b;
                r.held_count = HELD_ONE;
            end
            else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D))
            begin
                r = close_if_open(r);
            end
            else
            begin
                r = emit_byte(r, b);
            end
        end
        else if (b == qc)
        begin
            r = push(r, KIND_END, 8'h00);
            r.token_open = 1'b0;
            r.quote_kind = QUOTE_NONE;
        end
        else
        begin
            r = emit_byte(r, b);
        end
        return r;
    endfunction

    // full work for one input transfer
    function automatic work_t step(work_t w, logic [7:0] b, logic eoq);
        work_t r;
        r = w;
        case (w.held_count)
            HELD_NONE:
            begin
                r = feed(r, b);
            end
            HELD_ONE:
            begin
                if (w.held0 == 8'hC2 && b == 8'hA0)
                begin
                    r.held_count = HELD_NONE;
                    r = close_if_open(r);
                end
                else if (w.held0 != 8'hC2 && second_ok(w.held0, b))
                begin
                    r.held1      = b;
                    r.held_count = HELD_TWO;
                end
                else
                begin
                    r.held_count = HELD_NONE;
                    r = emit_byte(r, w.held0);
                    r = feed(r, b);
                end
            end
            default:
            begin
                r.held_count = HELD_NONE;
                if (triple_ok(w.held0, w.held1, b))
                begin
                    r = close_if_open(r);
                end
                else
                begin
                    r = emit_byte(r, w.held0);
                    r = emit_byte(r, w.held1);
                    r = feed(r, b);
                end
            end
        endcase
        if (eoq)
        begin
            if (r.held_count != HELD_NONE)
                r = emit_byte(r, r.held0);
            if (r.held_count == HELD_TWO)
                r = emit_byte(r, r.held1);
            if (r.escape_pending)
                r = push(r, KIND_ESC, 8'h00);
            else if (r.quote_kind != QUOTE_NONE)
                r = push(r, KIND_QUOTE, 8'h00);
            else
            begin
                r = close_if_open(r);
                r = push(r, KIND_DONE, 8'h00);
            end
            r.quote_kind     = QUOTE_NONE;
            r.escape_pending = 1'b0;
            r.held_count     = HELD_NONE;
            r.token_open     = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> design/quoted_token_splitter_unit.sv
// quoted_token_splitter_unit: top level of the quoted query tokenizer
// depends on qts_pkg (types, kind codes, per-byte step function)
//
// Takes query text one byte per transfer (tlast on the final byte) and splits
// it into tokens: whitespace and the UTF-8 space characters end a token outside
// quotes, single or double quotes enclose literal text, a backslash escapes
// the next byte. Every token byte is sent as its own result (kind 0), followed
// by a token end (kind 1); the final byte of a query closes with query done
// (kind 2), dangling escape (kind 3) or unclosed quote (kind 4), and on the
// last two the downstream side drops that query's tokens. One input byte yields
// zero to five results; tlast on the output marks the last result of a byte.
// The whole step for a byte is combinational logic from the state registers into
// a five-entry result register, so one byte is taken per cycle while each
// byte yields at most one result and the receiver is ready; the next byte is
// taken in the cycle the last result of the previous byte leaves.
module quoted_token_splitter_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_query
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] token_byte
    output logic [2:0] m_axis_tuser,   // [2:0] kind
    output logic       m_axis_tlast    // last_of_run
);

    import qts_pkg::*;

    // tokenizer state
    logic [1:0]           quote_kind_reg;
    logic                 escape_pending_reg;
    logic [1:0]           held_count_reg;
    logic                 token_open_reg;
    logic [7:0]           held0_reg;
    logic [7:0]           held1_reg;

    // result group waiting for the output side, entry 0 is the head
    res_t [RES_MAX-1:0]   ent_reg;
    logic [RES_CNT_W-1:0] cnt_reg;

    work_t                cur;
    work_t                nxt;
    logic                 in_xfer;
    logic                 out_xfer;

    // the head leaves as the next group arrives, so a single-result byte
    // stream keeps moving every cycle while the receiver is ready
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (cnt_reg == '0)
                           || ((cnt_reg == RES_CNT_W'(1)) && m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = ent_reg[0].tbyte;
    assign m_axis_tuser  = ent_reg[0].kind;
    assign m_axis_tlast  = (cnt_reg == RES_CNT_W'(1));

    // single-pass step: current state plus the incoming byte
    always_comb
    begin
        cur                = '0;
        cur.quote_kind     = quote_kind_reg;
        cur.escape_pending = escape_pending_reg;
        cur.held0          = held0_reg;
        cur.held1          = held1_reg;
        cur.held_count     = held_count_reg;
        cur.token_open     = token_open_reg;
        nxt                = step(cur, s_axis_tdata, s_axis_tlast);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_kind_reg     <= QUOTE_NONE;
            escape_pending_reg <= 1'b0;
            held_count_reg     <= HELD_NONE;
            token_open_reg     <= 1'b0;
            cnt_reg            <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                quote_kind_reg     <= nxt.quote_kind;
                escape_pending_reg <= nxt.escape_pending;
                held_count_reg     <= nxt.held_count;
                token_open_reg     <= nxt.token_open;
                cnt_reg            <= nxt.count;
            end
            else if (out_xfer)
            begin
                cnt_reg <= cnt_reg - RES_CNT_W'(1);
            end
        end
    end

    // payload: held bytes and the result entries
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            held0_reg <= nxt.held0;
            held1_reg <= nxt.held1;
            ent_reg   <= nxt.ent;
        end
        else if (out_xfer)
        begin
            ent_reg <= {ent_reg[RES_MAX-1], ent_reg[RES_MAX-1:1]};
        end
    end

`ifndef SYNTH
    // a group never holds more than five results
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RES_CNT_W'(RES_MAX))
        else $error("result count out of range");

    // a new byte is only taken once the previous group is gone or leaving
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ((cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && out_xfer)))
        else $error("result group overwritten");

    // bytes are only held when no escape is pending
    a_esc_held: assert property (@(posedge clk) disable iff (!rst_n)
        escape_pending_reg |-> (held_count_reg == HELD_NONE))
        else $error("escape pending with held bytes");

    // at most two held bytes
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("held count out of range");

    // the end of a query returns all state to its reset value
    a_query_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_axis_tlast) |=> ((quote_kind_reg == QUOTE_NONE)
            && !escape_pending_reg && (held_count_reg == HELD_NONE)
            && !token_open_reg))
        else $error("state not cleared after end of query");
`endif

endmodule

>>> tb/testbench.sv
// testbench for quoted_token_splitter_unit: byte stream in, token results out
// depends on qts_pkg (kind, quote and held-count codes) and the unit itself
`timescale 1ns / 1ps

module testbench;

    import qts_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    // one expected output transfer
    typedef struct {
        logic [7:0] tbyte;
        logic [2:0] kind;
        logic       eor;
    } tok_result_t;

    // independent model of the tokenizer plus the queue of awaited results
    class token_scoreboard;
        logic [1:0]  quote_st;
        logic        esc_pend;
        logic [7:0]  held [2];
        logic [1:0]  held_n;
        logic        tok_open;
        tok_result_t step_out [$];
        tok_result_t awaited [$];
        int          failures;
        int          checked;
        int          bytes_in;
        int          n_queries;
        int          n_tokens;
        int          n_done;
        int          n_esc;
        int          n_quote;

        function new();
            clear_state();
            held[0]   = 8'h00;
            held[1]   = 8'h00;
            failures  = 0;
            checked   = 0;
            bytes_in  = 0;
            n_queries = 0;
            n_tokens  = 0;
            n_done    = 0;
            n_esc     = 0;
            n_quote   = 0;
        endfunction

        function void clear_state();
            quote_st = QUOTE_NONE;
            esc_pend = 1'b0;
            held_n   = HELD_NONE;
            tok_open = 1'b0;
        endfunction

        function void put(logic [2:0] k, logic [7:0] b);
            tok_result_t r;
            r.tbyte = b;
            r.kind  = k;
            r.eor   = 1'b0;
            if (step_out.size() < RES_MAX)
                step_out = {step_out, r};
        endfunction

        function void put_byte(logic [7:0] b);
            put(KIND_BYTE, b);
            tok_open = 1'b1;
        endfunction

        function void end_token();
            if (tok_open)
            begin
                put(KIND_END, 8'h00);
                tok_open = 1'b0;
            end
        endfunction

        // first bytes of the utf-8 space characters
        function bit space_lead(logic [7:0] b);
            return b == 8'hC2 || b == 8'hE1 || b == 8'hE2 || b == 8'hE3;
        endfunction

        function bit second_fits(logic [7:0] lead, logic [7:0] b);
            case (lead)
                8'hE1:   return b == 8'h9A;
                8'hE2:   return b == 8'h80 || b == 8'h81;
                8'hE3:   return b == 8'h80;
                default: return 1'b0;
            endcase
        endfunction

        function bit space_triple(logic [7:0] a, logic [7:0] m, logic [7:0] c);
            if (a == 8'hE1)
                return m == 8'h9A && c == 8'h80;
            if (a == 8'hE2 && m == 8'h80)
                return (c >= 8'h80 && c <= 8'h8B) || c == 8'hA8 || c == 8'hA9 || c == 8'hAF;
            if (a == 8'hE2 && m == 8'h81)
                return c == 8'h9F;
            if (a == 8'hE3)
                return m == 8'h80 && c == 8'h80;
            return 1'b0;
        endfunction

        // escape, quote and whitespace rules for one byte
        function void plain_byte(logic [7:0] b);
            logic [7:0] close_q;
            logic [7:0] lit;
            close_q = (quote_st == QUOTE_DOUBLE) ? CH_DQUOTE : CH_SQUOTE;
            lit     = b;
            if (esc_pend)
            begin
                if (b == 8'h6E)
                    lit = 8'h0A;
                else if (b == 8'h74)
                    lit = 8'h09;
                else if (b == 8'h72)
                    lit = 8'h0D;
                put_byte(lit);
                esc_pend = 1'b0;
            end
            else if (b == CH_BSLASH)
                esc_pend = 1'b1;
            else if (quote_st == QUOTE_NONE)
            begin
                if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    end_token();
                    quote_st = (b == CH_DQUOTE) ? QUOTE_DOUBLE : QUOTE_SINGLE;
                end
                else if (space_lead(b))
                begin
                    held[0] = b;
                    held_n  = HELD_ONE;
                end
                else if (b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D))
                    end_token();
                else
                    put_byte(b);
            end
            else if (b == close_q)
            begin
                // a closing quote always ends a token, even an empty one
                put(KIND_END, 8'h00);
                tok_open = 1'b0;
                quote_st = QUOTE_NONE;
            end
            else
                put_byte(b);
        endfunction

        // an input transfer was accepted: work out what it must produce
        function void note_input(logic [7:0] b, logic eoq);
            logic [7:0] a;
            logic [7:0] m;
            step_out.delete();
            bytes_in++;
            a = held[0];
            m = held[1];
            case (held_n)
                HELD_NONE:
                    plain_byte(b);
                HELD_ONE:
                begin
                    if (a == 8'hC2 && b == 8'hA0)
                    begin
                        held_n = HELD_NONE;
                        end_token();
                    end
                    else if (a != 8'hC2 && second_fits(a, b))
                    begin
                        held[1] = b;
                        held_n  = HELD_TWO;
                    end
                    else
                    begin
                        // no space after all: lead byte is text, retry this one
                        held_n = HELD_NONE;
                        put_byte(a);
                        plain_byte(b);
                    end
                end
                default:
                begin
                    held_n = HELD_NONE;
                    if (space_triple(a, m, b))
                        end_token();
                    else
                    begin
                        put_byte(a);
                        put_byte(m);
                        plain_byte(b);
                    end
                end
            endcase
            if (eoq)
            begin
                // sequence cut by the end of the query becomes plain text
                if (held_n != HELD_NONE)
                    put_byte(held[0]);
                if (held_n == HELD_TWO)
                    put_byte(held[1]);
                if (esc_pend)
                begin
                    put(KIND_ESC, 8'h00);
                    n_esc++;
                end
                else if (quote_st != QUOTE_NONE)
                begin
                    put(KIND_QUOTE, 8'h00);
                    n_quote++;
                end
                else
                begin
                    end_token();
                    put(KIND_DONE, 8'h00);
                    n_done++;
                end
                clear_state();
                n_queries++;
            end
            foreach (step_out[i])
            begin
                step_out[i].eor = (i == step_out.size() - 1);
                if (step_out[i].kind == KIND_END)
                    n_tokens++;
                awaited = {awaited, step_out[i]};
            end
        endfunction

        function void report(string what, tok_result_t want, logic [7:0] d, logic [2:0] k,
                             logic l);
            failures++;
            if (failures <= 10)
                $display("%0t: %s: expected byte %02h kind %0d last %0d, %s %02h kind %0d last %0d",
                         $realtime, what, want.tbyte, want.kind, want.eor, "got byte",
                         d, k, l);
        endfunction

        // an output transfer was accepted: compare with the oldest expectation
        function void check_result(logic [7:0] d, logic [2:0] k, logic l);
            tok_result_t want;
            checked++;
            if (awaited.size() == 0)
            begin
                want = '{tbyte: 8'h00, kind: KIND_BYTE, eor: 1'b0};
                report("unexpected result", want, d, k, l);
                return;
            end
            want = awaited.pop_front();
            if (want.tbyte !== d || want.kind !== k || want.eor !== l)
                report("result mismatch", want, d, k, l);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    token_scoreboard sb = new();

    int idle_pct  = 0;   // chance per cycle that the sender holds back
    int stall_pct = 0;   // chance per cycle that the receiver stalls

    quoted_token_splitter_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
        .s_axis_tlast  (s_axis_tlast),   // end_of_query
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] token_byte
        .m_axis_tuser  (m_axis_tuser),   // [2:0] kind
        .m_axis_tlast  (m_axis_tlast)    // last_of_run
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver side: random backpressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // every accepted output transfer is checked
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    // one input transfer, after a random gap; returns at the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic eoq);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoq;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_input(b, eoq);
    endtask

    task automatic send_query(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    // sender holds off until every expected result has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // one random fragment of query text, mostly well formed
    function automatic void add_piece(ref byte_q_t q);
        logic [7:0] ws [6]   = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
        logic [7:0] lead [4] = '{8'hC2, 8'hE1, 8'hE2, 8'hE3};
        logic [7:0] tail [15] = '{8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
                                  8'h88, 8'h89, 8'h8A, 8'h8B, 8'hA8, 8'hA9, 8'hAF};
        logic [7:0] esc [4]  = '{8'h6E, 8'h74, 8'h72, 8'h00};
        logic [7:0] ld;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 33)
            q = {q, 8'($urandom_range(8'h21, 8'h7E))};
        else if (pick < 45)
            q = {q, ws[$urandom_range(0, 5)]};
        else if (pick < 53)
            q = {q, ($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE)};
        else if (pick < 61)
        begin
            esc[3] = 8'($urandom);
            q = {q, CH_BSLASH, esc[$urandom_range(0, 3)]};
        end
        else if (pick < 79)
        begin
            // a complete utf-8 space
            case ($urandom_range(0, 4))
                0: q = {q, 8'hC2, 8'hA0};
                1: q = {q, 8'hE1, 8'h9A, 8'h80};
                2: q = {q, 8'hE2, 8'h80, tail[$urandom_range(0, 14)]};
                3: q = {q, 8'hE2, 8'h81, 8'h9F};
                default: q = {q, 8'hE3, 8'h80, 8'h80};
            endcase
        end
        else if (pick < 91)
        begin
            // broken space sequence, retried as plain bytes
            ld = lead[$urandom_range(0, 3)];
            q = {q, ld};
            if (ld != 8'hC2 && $urandom_range(0, 1))
                q = {q, ((ld == 8'hE1) ? 8'h9A : (($urandom_range(0, 1)) ? 8'h80 : 8'h81))};
            if ($urandom_range(0, 3) != 0)
                q = {q, 8'($urandom)};
        end
        else
            q = {q, 8'($urandom)};
    endfunction

    task automatic run_directed();
        send_query('{8'h00});
        send_query('{8'hFF, 8'h0D, 8'h41});
        // empty double-quoted token, single quotes keep the space
        send_query('{CH_DQUOTE, CH_DQUOTE, CH_SQUOTE, 8'h78, CH_SPACE, 8'h79, CH_SQUOTE});
        // escaped n, t, r, other, then a dangling escape
        send_query('{CH_BSLASH, 8'h6E, CH_BSLASH, 8'h74, CH_BSLASH, 8'h72, CH_BSLASH, 8'h71,
                     CH_BSLASH});
        // dangling escape wins over an unclosed quote
        send_query('{CH_DQUOTE, CH_BSLASH});
        send_query('{CH_SQUOTE, 8'h61});
        send_query('{8'h61, 8'hC2, 8'hA0, 8'h62, 8'hE1, 8'h9A, 8'h80, 8'h63});
        // two held bytes plus a letter and the end: five results
        send_query('{8'hE2, 8'h80, 8'h41});
        send_query('{8'hE2, 8'h80, 8'hE2, 8'h80, 8'h80, 8'hC2});
    endtask

    task automatic run_random(input int quota);
        byte_q_t q;
        int      sent;
        int      n_pieces;
        sent = 0;
        while (sent < quota)
        begin
            q.delete();
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: raw bytes
                repeat ($urandom_range(1, 6))
                    q = {q, 8'($urandom)};
            end
            else
            begin
                n_pieces = $urandom_range(1, 6);
                repeat (n_pieces)
                    add_piece(q);
            end
            send_query(q);
            sent += q.size();
        end
    endtask

    initial
    begin
        int send_idle [4]  = '{0, 74, 0, 31};
        int recv_stall [4] = '{0, 0, 74, 31};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = send_idle[ph];
            stall_pct = recv_stall[ph];
            run_random(16);
            // short stretch with no idling inside each phase
            idle_pct  = 0;
            stall_pct = 0;
            run_random(4);
            idle_pct  = send_idle[ph];
            stall_pct = recv_stall[ph];
            run_random(13);
            drain();
        end

        stall_pct = 0;
        repeat (20) @(posedge clk);

        $display("covered %0d input bytes in %0d queries, %0d results checked",
                 sb.bytes_in, sb.n_queries, sb.checked);
        $display("%0d tokens closed, %0d clean ends, %0d dangling escapes, %0d unclosed quotes",
                 sb.n_tokens, sb.n_done, sb.n_esc, sb.n_quote);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
design/qts_pkg.sv
design/quoted_token_splitter_unit.sv
tb/testbench.sv
